>>> src/blocking_byte_pipe_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for blocking_byte_pipe
// Clocked on clk; the reset-aware form is disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef BLOCKING_BYTE_PIPE_ASSERT_SVH
`define BLOCKING_BYTE_PIPE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define BBP_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("blocking_byte_pipe assertion failed");
`define BBP_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("blocking_byte_pipe assertion failed");
`else
`define BBP_ASSERT(label, prop)
`define BBP_ASSERT_ALWAYS(label, prop)
`endif

`endif

>>> src/bbp_pkg.sv
// ---------------------------------------------------------------------------
// bbp_pkg
// Shared types and field widths of the blocking byte pipe.
// ---------------------------------------------------------------------------
package bbp_pkg;

	localparam int TASK_W  = 4;
	localparam int BYTE_W  = 8;
	localparam int FILL_W  = 9;
	localparam int TOTAL_W = 32;

	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 88;

	typedef enum logic [1:0] {
		ACT_WRITE = 2'd0,
		ACT_READ  = 2'd1,
		ACT_CLEAR = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_WRITTEN = 3'd0,
		ST_READ    = 3'd1,
		ST_BLOCKED = 3'd2,
		ST_EMPTY   = 3'd3,
		ST_CLEARED = 3'd4
	} status_t;

	// Result in flight between the state update and the output register
	typedef struct packed {
		status_t              status;
		logic                 byte_rd;    // read_byte comes from the byte store
		logic                 woken_valid;
		logic                 woken_wr;   // released task is from the writer queue
		logic                 call_done;
		logic [FILL_W-1:0]    fill_count;
		logic [TOTAL_W-1:0]   blk_rd_total;
		logic [TOTAL_W-1:0]   blk_wr_total;
	} result_t;

endpackage

>>> src/blocking_byte_pipe.sv
// ---------------------------------------------------------------------------
// blocking_byte_pipe
// Byte FIFO between tasks with queues of waiting readers and writers.
// ---------------------------------------------------------------------------
// One transaction is taken per clock unless stalled; its result passes the
// stage and output registers (the unused action gives none). Counts,
// indexes and blocked totals are registers updated in the accept cycle;
// the bytes and the waiting task ids sit in three RAMs with registered read
// data, read in the accept cycle and picked up when the output register
// loads. The input stalls only when a result is held in the stage register
// and the output register is also full and not being taken. Reset and the
// clear action empty the FIFO and both queues at once, with no clearing pass.
module blocking_byte_pipe import bbp_pkg::*; #(
	parameter int FIFO_DEPTH = 256,
	parameter int MAX_TASKS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [7:0] data_byte, [11:8] task_id, [12] may_block, [15:13] zero
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// [1:0] action
	input  logic [1:0]            s_tuser,
	input  logic                  s_tlast,     // last_of_call
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [7:0] read_byte, [8] woken_valid, [12:9] woken_task, [21:13] fill_count,
	// [53:22] blocked_read_total, [85:54] blocked_write_total, [87:86] zero
	output logic [OUT_DATA_W-1:0] m_tdata,
	// [2:0] status
	output logic [2:0]            m_tuser,
	output logic                  m_tlast      // call_done
);

	`include "blocking_byte_pipe_assert.svh"

	localparam int AW  = $clog2(FIFO_DEPTH);
	localparam int CW  = $clog2(FIFO_DEPTH + 1);
	localparam int QW  = $clog2(MAX_TASKS);
	localparam int QCW = $clog2(MAX_TASKS + 1);

	// input fields
	action_t           in_action;
	logic [BYTE_W-1:0] in_byte;
	logic [TASK_W-1:0] in_task;
	logic              in_may_block;
	logic              s_acc;
	logic              out_free;

	assign in_action    = action_t'(s_tuser);
	assign in_byte      = s_tdata[7:0];
	assign in_task      = s_tdata[11:8];
	assign in_may_block = s_tdata[12];

	// architectural state
	logic [AW-1:0]      wr_idx_q, rd_idx_q;
	logic [CW-1:0]      cnt_q;
	logic [QW-1:0]      rq_head_q, wq_head_q;
	logic [QCW-1:0]     rq_cnt_q, wq_cnt_q;
	logic [TOTAL_W-1:0] blk_rd_q, blk_wr_q;

	logic [AW-1:0]      wr_idx_d, rd_idx_d;
	logic [CW-1:0]      cnt_d;
	logic [QW-1:0]      rq_head_d, wq_head_d;
	logic [QCW-1:0]     rq_cnt_d, wq_cnt_d;
	logic [TOTAL_W-1:0] blk_rd_d, blk_wr_d;

	// memory controls
	logic              fifo_we, fifo_re;
	logic              rq_we, rq_re, wq_we, wq_re;
	logic [QW-1:0]     rq_tail, wq_tail;
	logic [QCW:0]      rq_sum, wq_sum;
	logic [BYTE_W-1:0] fifo_rdata;
	logic [TASK_W-1:0] rq_rdata, wq_rdata;

	result_t res;
	result_t res_s1;
	logic    valid_s1;

	// slot behind the last queued id, wrapped at the queue depth
	assign rq_sum  = (QCW+1)'(rq_head_q) + (QCW+1)'(rq_cnt_q);
	assign wq_sum  = (QCW+1)'(wq_head_q) + (QCW+1)'(wq_cnt_q);
	assign rq_tail = (rq_sum >= (QCW+1)'(MAX_TASKS)) ?
		QW'(rq_sum - (QCW+1)'(MAX_TASKS)) : QW'(rq_sum);
	assign wq_tail = (wq_sum >= (QCW+1)'(MAX_TASKS)) ?
		QW'(wq_sum - (QCW+1)'(MAX_TASKS)) : QW'(wq_sum);

	assign out_free = !m_tvalid || m_tready;
	assign s_tready = !valid_s1 || out_free;
	assign s_acc    = s_tvalid && s_tready;

	always_comb begin
		wr_idx_d  = wr_idx_q;
		rd_idx_d  = rd_idx_q;
		cnt_d     = cnt_q;
		rq_head_d = rq_head_q;
		wq_head_d = wq_head_q;
		rq_cnt_d  = rq_cnt_q;
		wq_cnt_d  = wq_cnt_q;
		blk_rd_d  = blk_rd_q;
		blk_wr_d  = blk_wr_q;
		fifo_we   = 1'b0;
		fifo_re   = 1'b0;
		rq_we     = 1'b0;
		rq_re     = 1'b0;
		wq_we     = 1'b0;
		wq_re     = 1'b0;
		res             = '0;
		res.status      = ST_WRITTEN;

		case (in_action)
			ACT_WRITE: begin
				if (cnt_q < CW'(FIFO_DEPTH)) begin
					fifo_we  = 1'b1;
					wr_idx_d = (wr_idx_q == AW'(FIFO_DEPTH - 1)) ? '0 : wr_idx_q + 1'b1;
					cnt_d    = cnt_q + 1'b1;
					if (rq_cnt_q != '0) begin
						rq_re     = 1'b1;
						rq_head_d = (rq_head_q == QW'(MAX_TASKS - 1)) ? '0 : rq_head_q + 1'b1;
						rq_cnt_d  = rq_cnt_q - 1'b1;
						res.woken_valid = 1'b1;
					end
					res.status    = ST_WRITTEN;
					res.call_done = s_tlast;
				end else begin
					blk_wr_d = blk_wr_q + 1'b1;
					if (wq_cnt_q < QCW'(MAX_TASKS)) begin
						wq_we    = 1'b1;
						wq_cnt_d = wq_cnt_q + 1'b1;
					end
					res.status = ST_BLOCKED;
				end
			end
			ACT_READ: begin
				if (cnt_q != '0) begin
					fifo_re  = 1'b1;
					rd_idx_d = (rd_idx_q == AW'(FIFO_DEPTH - 1)) ? '0 : rd_idx_q + 1'b1;
					cnt_d    = cnt_q - 1'b1;
					if (wq_cnt_q != '0) begin
						wq_re     = 1'b1;
						wq_head_d = (wq_head_q == QW'(MAX_TASKS - 1)) ? '0 : wq_head_q + 1'b1;
						wq_cnt_d  = wq_cnt_q - 1'b1;
						res.woken_valid = 1'b1;
						res.woken_wr    = 1'b1;
					end
					res.status    = ST_READ;
					res.byte_rd   = 1'b1;
					res.call_done = s_tlast;
				end else if (in_may_block) begin
					blk_rd_d = blk_rd_q + 1'b1;
					if (rq_cnt_q < QCW'(MAX_TASKS)) begin
						rq_we    = 1'b1;
						rq_cnt_d = rq_cnt_q + 1'b1;
					end
					res.status = ST_BLOCKED;
				end else begin
					res.status    = ST_EMPTY;
					res.call_done = 1'b1;
				end
			end
			ACT_CLEAR: begin
				wr_idx_d  = '0;
				rd_idx_d  = '0;
				cnt_d     = '0;
				rq_head_d = '0;
				wq_head_d = '0;
				rq_cnt_d  = '0;
				wq_cnt_d  = '0;
				blk_rd_d  = '0;
				blk_wr_d  = '0;
				res.status    = ST_CLEARED;
				res.call_done = 1'b1;
			end
			default: begin
			end
		endcase

		res.fill_count   = FILL_W'(cnt_d);
		res.blk_rd_total = blk_rd_d;
		res.blk_wr_total = blk_wr_d;
	end

	bbp_ram #(.WIDTH(BYTE_W), .DEPTH(FIFO_DEPTH)) u_byte_ram (
		.clk   (clk),
		.we    (s_acc && fifo_we),
		.waddr (wr_idx_q),
		.wdata (in_byte),
		.re    (s_acc && fifo_re),
		.raddr (rd_idx_q),
		.rdata (fifo_rdata)
	);

	bbp_ram #(.WIDTH(TASK_W), .DEPTH(MAX_TASKS)) u_reader_ram (
		.clk   (clk),
		.we    (s_acc && rq_we),
		.waddr (rq_tail),
		.wdata (in_task),
		.re    (s_acc && rq_re),
		.raddr (rq_head_q),
		.rdata (rq_rdata)
	);

	bbp_ram #(.WIDTH(TASK_W), .DEPTH(MAX_TASKS)) u_writer_ram (
		.clk   (clk),
		.we    (s_acc && wq_we),
		.waddr (wq_tail),
		.wdata (in_task),
		.re    (s_acc && wq_re),
		.raddr (wq_head_q),
		.rdata (wq_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q  <= '0;
			rd_idx_q  <= '0;
			cnt_q     <= '0;
			rq_head_q <= '0;
			wq_head_q <= '0;
			rq_cnt_q  <= '0;
			wq_cnt_q  <= '0;
			blk_rd_q  <= '0;
			blk_wr_q  <= '0;
		end else if (s_acc) begin
			wr_idx_q  <= wr_idx_d;
			rd_idx_q  <= rd_idx_d;
			cnt_q     <= cnt_d;
			rq_head_q <= rq_head_d;
			wq_head_q <= wq_head_d;
			rq_cnt_q  <= rq_cnt_d;
			wq_cnt_q  <= wq_cnt_d;
			blk_rd_q  <= blk_rd_d;
			blk_wr_q  <= blk_wr_d;
		end
	end

	// stage 1 waits for the RAM read data; RAM outputs hold while it stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_acc) begin
			valid_s1 <= (in_action != ACT_NONE);
		end else if (out_free) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			res_s1 <= res;
		end
	end

	// output register
	logic [BYTE_W-1:0] out_byte;
	logic [TASK_W-1:0] out_task;

	assign out_byte = res_s1.byte_rd ? fifo_rdata : '0;
	assign out_task = !res_s1.woken_valid ? '0 : (res_s1.woken_wr ? wq_rdata : rq_rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_free) begin
			m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			m_tdata <= {2'b00, res_s1.blk_wr_total, res_s1.blk_rd_total,
				res_s1.fill_count, out_task, res_s1.woken_valid, out_byte};
			m_tuser <= res_s1.status;
			m_tlast <= res_s1.call_done;
		end
	end

	// a waiting reader means the FIFO went empty, a waiting writer that it was full
	`BBP_ASSERT(a_one_queue_waits, !(rq_cnt_q != '0 && wq_cnt_q != '0))
	`BBP_ASSERT(a_fill_bound, cnt_q <= CW'(FIFO_DEPTH))
	`BBP_ASSERT(a_full_write_counts,
		(s_acc && in_action == ACT_WRITE && cnt_q == CW'(FIFO_DEPTH))
		|=> (blk_wr_q == $past(blk_wr_q) + 1'b1))
	`BBP_ASSERT(a_stage_stall, (valid_s1 && m_tvalid && !m_tready) |-> !s_tready)
	`BBP_ASSERT_ALWAYS(a_reset_empty, !arst_n |=> (cnt_q == '0 || arst_n))

endmodule

>>> src/bbp_ram.sv
// ---------------------------------------------------------------------------
// bbp_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module bbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: blocking_byte_pipe testbench
// Drives write, read and clear calls over the slave stream and scores each
// master-side transaction against a cycle-free model of the byte FIFO and
// its two waiter queues. Both handshakes idle at random in two of three phases.
// ---------------------------------------------------------------------------
module tb_top;
	import bbp_pkg::*;

	localparam int PIPE_DEPTH  = 256;
	localparam int WAITER_SLOTS = 16;
	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_CYCLES = 8;

	typedef struct packed {
		status_t      status;
		logic [7:0]   rd_byte;
		logic         woke;
		logic [3:0]   woke_id;
		logic         done;
		logic [8:0]   fill;
		logic [31:0]  blk_rd;
		logic [31:0]  blk_wr;
	} pipe_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [1:0]            s_tuser = '0;
	logic                  s_tlast = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [2:0]            m_tuser;
	logic                  m_tlast;

	// model state
	logic [7:0]  byte_ring [PIPE_DEPTH];
	logic [7:0]  ring_wr_ptr;
	logic [7:0]  ring_rd_ptr;
	logic [8:0]  ring_fill;
	logic [3:0]  reader_ids [WAITER_SLOTS];
	logic [3:0]  reader_head;
	logic [4:0]  reader_cnt;
	logic [3:0]  writer_ids [WAITER_SLOTS];
	logic [3:0]  writer_head;
	logic [4:0]  writer_cnt;
	logic [31:0] blk_rd_total;
	logic [31:0] blk_wr_total;

	pipe_result_t pending_results[$];
	int mismatches = 0;
	int items_sent = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	blocking_byte_pipe uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic void clear_model();
		ring_wr_ptr  = '0;
		ring_rd_ptr  = '0;
		ring_fill    = '0;
		reader_head  = '0;
		reader_cnt   = '0;
		writer_head  = '0;
		writer_cnt   = '0;
		blk_rd_total = '0;
		blk_wr_total = '0;
	endfunction

	// Advance the model by one accepted call; returns 0 when no result is due.
	function automatic bit pipe_step(action_t act, logic [7:0] data, logic [3:0] tid,
			logic may_block, logic last, output pipe_result_t res);
		logic [3:0] slot;
		res = '0;
		case (act)
			ACT_WRITE: begin
				if (ring_fill < PIPE_DEPTH) begin
					byte_ring[ring_wr_ptr] = data;
					ring_wr_ptr++;
					ring_fill++;
					if (reader_cnt != 0) begin
						res.woke = 1'b1;
						res.woke_id = reader_ids[reader_head];
						reader_head++;
						reader_cnt--;
					end
					res.status = ST_WRITTEN;
					res.done = last;
				end else begin
					blk_wr_total++;
					if (writer_cnt < WAITER_SLOTS) begin
						slot = writer_head + writer_cnt[3:0];
						writer_ids[slot] = tid;
						writer_cnt++;
					end
					res.status = ST_BLOCKED;
				end
			end
			ACT_READ: begin
				if (ring_fill != 0) begin
					res.rd_byte = byte_ring[ring_rd_ptr];
					ring_rd_ptr++;
					ring_fill--;
					if (writer_cnt != 0) begin
						res.woke = 1'b1;
						res.woke_id = writer_ids[writer_head];
						writer_head++;
						writer_cnt--;
					end
					res.status = ST_READ;
					res.done = last;
				end else if (may_block) begin
					blk_rd_total++;
					// queue full: still counted, id dropped
					if (reader_cnt < WAITER_SLOTS) begin
						slot = reader_head + reader_cnt[3:0];
						reader_ids[slot] = tid;
						reader_cnt++;
					end
					res.status = ST_BLOCKED;
				end else begin
					res.status = ST_EMPTY;
					res.done = 1'b1;
				end
			end
			ACT_CLEAR: begin
				clear_model();
				res.status = ST_CLEARED;
				res.done = 1'b1;
			end
			default: return 1'b0;
		endcase
		res.fill = ring_fill;
		res.blk_rd = blk_rd_total;
		res.blk_wr = blk_wr_total;
		return 1'b1;
	endfunction

	function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		pipe_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("result transaction with nothing expected");
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", want.status, m_tuser);
				check_field("read_byte", want.rd_byte, m_tdata[7:0]);
				check_field("woken_valid", want.woke, m_tdata[8]);
				check_field("woken_task", want.woke_id, m_tdata[12:9]);
				check_field("call_done", want.done, m_tlast);
				check_field("fill_count", want.fill, m_tdata[21:13]);
				check_field("blocked_read_total", want.blk_rd, m_tdata[53:22]);
				check_field("blocked_write_total", want.blk_wr, m_tdata[85:54]);
			end
		end
	end

	task automatic send_op(action_t act, logic [7:0] data, logic [3:0] tid,
			logic may_block, logic last);
		pipe_result_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b000, may_block, tid, data};
		s_tuser  <= act;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		if (pipe_step(act, data, tid, may_block, last, res)) begin
			pending_results.push_back(res);
			items_sent++;
		end
	endtask

	// hold the input off until every outstanding result has drained
	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic write_call(int len, logic [3:0] tid);
		for (int i = 0; i < len; i++)
			send_op(ACT_WRITE, 8'($urandom_range(255)), tid, 1'($urandom_range(1)),
				i == len - 1);
	endtask

	task automatic read_call(int len, logic [3:0] tid);
		for (int i = 0; i < len; i++)
			send_op(ACT_READ, 8'($urandom_range(255)), tid, i == 0, i == len - 1);
	endtask

	task automatic test_directed();
		send_op(ACT_READ, 8'h00, 4'd1, 1'b0, 1'b0);   // empty, no blocking
		send_op(ACT_READ, 8'hFF, 4'd15, 1'b1, 1'b0);  // blocks, reader 15 queued
		send_op(ACT_READ, 8'h00, 4'd0, 1'b1, 1'b1);   // blocks, reader 0 queued
		send_op(ACT_WRITE, 8'h00, 4'd3, 1'b0, 1'b0);  // wakes reader 15
		send_op(ACT_WRITE, 8'hFF, 4'd12, 1'b1, 1'b1); // wakes reader 0
		send_op(ACT_WRITE, 8'hA5, 4'd5, 1'b0, 1'b1);
		send_op(ACT_READ, 8'h00, 4'd7, 1'b1, 1'b0);
		send_op(ACT_READ, 8'h00, 4'd7, 1'b0, 1'b1);
		send_op(ACT_NONE, 8'($urandom_range(255)), 4'($urandom_range(15)), 1'b1, 1'b1);
		send_op(ACT_READ, 8'hFF, 4'd8, 1'b0, 1'b1);
		send_op(ACT_READ, 8'h00, 4'd8, 1'b0, 1'b0);   // empty again
		send_op(ACT_WRITE, 8'h5A, 4'd2, 1'b0, 1'b0);
		send_op(ACT_CLEAR, 8'hFF, 4'd15, 1'b1, 1'b0); // clears data and counters
		send_op(ACT_CLEAR, 8'h00, 4'd0, 1'b0, 1'b1);
		send_op(ACT_READ, 8'h00, 4'd9, 1'b1, 1'b0);
		send_op(ACT_CLEAR, 8'h00, 4'd0, 1'b0, 1'b0);  // drops queued reader
		send_op(ACT_WRITE, 8'h3C, 4'd4, 1'b0, 1'b1);  // nobody to wake
		send_op(ACT_READ, 8'h00, 4'd4, 1'b1, 1'b1);
	endtask

	// fill to the brim, overflow the writer queue, release some, clear, write again
	task automatic test_full_pipe();
		int len;
		while (ring_fill < PIPE_DEPTH) begin
			len = $urandom_range(16, 1);
			if (len > PIPE_DEPTH - ring_fill)
				len = PIPE_DEPTH - ring_fill;
			write_call(len, 4'($urandom_range(15)));
		end
		for (int i = 0; i < 20; i++)
			send_op(ACT_WRITE, 8'($urandom_range(255)), 4'($urandom_range(15)),
				1'($urandom_range(1)), 1'($urandom_range(1)));
		read_call(10, 4'($urandom_range(15)));
		send_op(ACT_CLEAR, 8'($urandom_range(255)), 4'($urandom_range(15)), 1'b0, 1'b0);
		send_op(ACT_WRITE, 8'($urandom_range(255)), 4'd6, 1'b0, 1'b1);
		read_call(2, 4'd6);
	endtask

	// overflow the reader queue on an empty pipe, then feed the sleepers
	task automatic test_waiting_readers();
		while (ring_fill != 0)
			read_call(8, 4'($urandom_range(15)));
		for (int i = 0; i < 20; i++)
			send_op(ACT_READ, 8'($urandom_range(255)), 4'($urandom_range(15)), 1'b1,
				1'($urandom_range(1)));
		for (int i = 0; i < 20; i++)
			write_call(1, 4'($urandom_range(15)));
		read_call(20, 4'($urandom_range(15)));
	endtask

	task automatic test_random_calls(int quota);
		int stop_at;
		int pick;
		stop_at = items_sent + quota;
		wait_for_drain();
		while (items_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 42)
				write_call($urandom_range(8, 1), 4'($urandom_range(15)));
			else if (pick < 84)
				read_call($urandom_range(8, 1), 4'($urandom_range(15)));
			else if (pick < 88) begin
				if ($urandom_range(1))
					wait_for_drain();
				send_op(ACT_CLEAR, 8'($urandom_range(255)), 4'($urandom_range(15)),
					1'($urandom_range(1)), 1'($urandom_range(1)));
			end else if (pick < 91)
				send_op(ACT_NONE, 8'($urandom_range(255)), 4'($urandom_range(15)),
					1'($urandom_range(1)), 1'($urandom_range(1)));
			else
				send_op(action_t'($urandom_range(1)), 8'($urandom_range(255)),
					4'($urandom_range(15)), 1'($urandom_range(1)), 1'($urandom_range(1)));
		end
	endtask

	initial begin
		clear_model();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 11;
		recv_idle_pct = 86;
		test_directed();
		test_full_pipe();

		send_idle_pct = 86;
		recv_idle_pct = 11;
		test_waiting_readers();
		test_random_calls(240);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_calls(240);

		wait_for_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
